FILE: hdl/bpcl_pkg.sv
// Package for the button press code lock.
// Holds the configuration types, register indexes and fixed limits.
// No dependencies.
`timescale 1ns / 1ps

package bpcl_pkg;

    localparam int ElapsedW   = 10;
    localparam int WindowW    = 20;
    localparam int LimitW     = 18;   // 255 * 1000 fits in 18 bits
    localparam int PressW     = 5;
    localparam int PosW       = 2;
    localparam int HoldW      = 14;
    localparam int DigitW     = 4;
    localparam int CfgIdxW    = 3;
    localparam int CfgDataW   = 8;

    localparam logic [PressW-1:0]  PRESS_MAX     = 5'd31;
    localparam logic [WindowW-1:0] WINDOW_MAX    = 20'hFFFFF;
    localparam logic [HoldW-1:0]   HOLD_MAX      = 14'h3FFF;
    localparam logic [9:0]         MS_PER_SECOND = 10'd1000;
    localparam logic [PosW-1:0]    LAST_POS      = 2'd3;

    // Register indexes of the configuration port
    typedef enum logic [CfgIdxW-1:0] {
        CFG_WINDOW_SECONDS = 3'd0,
        CFG_DIGIT_ONE      = 3'd1,
        CFG_DIGIT_TWO      = 3'd2,
        CFG_DIGIT_THREE    = 3'd3,
        CFG_CODE_LENGTH    = 3'd4,
        CFG_LOCK_ENABLE    = 3'd5
    } t_cfg_idx;

    // Configuration as seen by the lock logic
    typedef struct packed {
        logic [LimitW-1:0] window_limit;  // window length in ms
        logic [DigitW-1:0] digit_one;
        logic [DigitW-1:0] digit_two;
        logic [DigitW-1:0] digit_three;
        logic [PosW-1:0]   code_length;
        logic              lock_enable;
    } t_cfg;

endpackage

FILE: hdl/bpcl_in_if.sv
// Input tick channel of the button press code lock.
// Valid/ready handshake with the tick payload; uses bpcl_pkg widths.
`timescale 1ns / 1ps

interface bpcl_in_if;
    logic                          valid;
    logic                          ready;
    logic [bpcl_pkg::ElapsedW-1:0] elapsed_ms;
    logic                          level_changed;
    logic                          is_pressed;

    modport source (output valid, elapsed_ms, level_changed, is_pressed, input ready);
    modport sink   (input valid, elapsed_ms, level_changed, is_pressed, output ready);
endinterface

FILE: hdl/bpcl_out_if.sv
// Result channel of the button press code lock.
// Valid/ready handshake with the four result flags. No dependencies.
`timescale 1ns / 1ps

interface bpcl_out_if;
    logic valid;
    logic ready;
    logic power_on;
    logic force_off;
    logic blink_blue;
    logic entering_code;

    modport source (output valid, power_on, force_off, blink_blue, entering_code,
                    input ready);
    modport sink   (input valid, power_on, force_off, blink_blue, entering_code,
                    output ready);
endinterface

FILE: hdl/button_press_code_lock_unit.sv
// Top level of the button press code lock: tick handling and result register.
// Depends on bpcl_pkg, bpcl_in_if, bpcl_out_if and bpcl_cfg_regs.
//
//  Channel  | Direction | Handshake       | Payload
//  ---------+-----------+-----------------+---------------------------------------------
//  i_in     | in        | valid/ready     | elapsed_ms[9:0], level_changed, is_pressed
//  o_out    | out       | valid/ready     | power_on, force_off, blink_blue, entering_code
//  i_cfg_*  | in        | write enable    | i_cfg_idx[2:0], i_cfg_data[7:0]
//
// One tick per cycle unless o_out stalls; a tick's result is valid next cycle.
// The lock state and result register update in the same edge that accepts a tick.
// A tick is accepted while the result register is empty or being drained.
// Reset is synchronous; it clears the lock state and loads the register defaults.
`timescale 1ns / 1ps

module button_press_code_lock_unit #(
    parameter int LONG_PRESS_MS = 5000
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    bpcl_in_if.sink                       i_in,
    bpcl_out_if.source                    o_out,
    input  logic                          i_cfg_we,
    input  logic [bpcl_pkg::CfgIdxW-1:0]  i_cfg_idx,
    input  logic [bpcl_pkg::CfgDataW-1:0] i_cfg_data
);

    localparam logic [bpcl_pkg::HoldW-1:0] HoldLimit = bpcl_pkg::HoldW'(LONG_PRESS_MS);

    bpcl_pkg::t_cfg w_cfg;

    logic                            r_entry, n_entry;
    logic [bpcl_pkg::WindowW-1:0]    r_wtimer, n_wtimer;
    logic [bpcl_pkg::PressW-1:0]     r_count, n_count;
    logic [bpcl_pkg::PosW-1:0]       r_pos, n_pos;
    logic [bpcl_pkg::HoldW-1:0]      r_hold, n_hold;

    logic r_out_valid;
    logic r_power_on, n_power_on;
    logic r_force_off, n_force_off;
    logic r_blink, n_blink;

    logic                          w_accept;
    logic                          w_press;
    logic [bpcl_pkg::WindowW:0]    w_wsum;
    logic [bpcl_pkg::WindowW-1:0]  w_wsat;
    logic [bpcl_pkg::PressW-1:0]   w_count_inc;
    logic [bpcl_pkg::DigitW-1:0]   w_digit;
    logic [bpcl_pkg::HoldW:0]      w_hsum;
    logic [bpcl_pkg::HoldW-1:0]    w_hold_upd;

    bpcl_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    // Take a tick whenever the result register can be refilled
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_press    = i_in.level_changed && i_in.is_pressed;

    // Window timer and press count, saturating
    assign w_wsum      = {1'b0, r_wtimer} + (bpcl_pkg::WindowW + 1)'(i_in.elapsed_ms);
    assign w_wsat      = w_wsum[bpcl_pkg::WindowW] ? bpcl_pkg::WINDOW_MAX
                                                   : w_wsum[bpcl_pkg::WindowW-1:0];
    assign w_count_inc = (w_press && r_count < bpcl_pkg::PRESS_MAX) ? r_count + 1'b1
                                                                    : r_count;

    // Required count for the current position
    always_comb begin
        case (r_pos)
            2'd1:    w_digit = w_cfg.digit_one;
            2'd2:    w_digit = w_cfg.digit_two;
            2'd3:    w_digit = w_cfg.digit_three;
            default: w_digit = '0;
        endcase
    end

    // Entry state update for one tick
    always_comb begin
        n_entry    = r_entry;
        n_wtimer   = r_wtimer;
        n_count    = r_count;
        n_pos      = r_pos;
        n_power_on = 1'b0;
        n_blink    = 1'b0;
        if (r_entry) begin
            n_wtimer = w_wsat;
            n_count  = w_count_inc;
            if (w_wsat > bpcl_pkg::WindowW'(w_cfg.window_limit)) begin
                n_wtimer = '0;
                if (w_count_inc == bpcl_pkg::PressW'(w_digit)) begin
                    if (r_pos == w_cfg.code_length || r_pos == bpcl_pkg::LAST_POS) begin
                        n_power_on = 1'b1;
                        n_entry    = 1'b0;
                    end else begin
                        n_pos   = r_pos + 1'b1;
                        n_count = '0;
                        n_blink = 1'b1;
                    end
                end else begin
                    n_entry = 1'b0;
                end
            end
        end else if (w_press) begin
            if (w_cfg.code_length != '0 && w_cfg.lock_enable) begin
                n_entry  = 1'b1;
                n_count  = bpcl_pkg::PressW'(1);
                n_wtimer = '0;
                n_pos    = bpcl_pkg::PosW'(1);
            end else begin
                n_power_on = 1'b1;
            end
        end
    end

    // Hold timer: restart on change, saturate otherwise, fire on a long hold
    assign w_hsum     = {1'b0, r_hold} + (bpcl_pkg::HoldW + 1)'(i_in.elapsed_ms);
    assign w_hold_upd = i_in.level_changed ? '0
                      : (w_hsum[bpcl_pkg::HoldW] ? bpcl_pkg::HOLD_MAX
                                                 : w_hsum[bpcl_pkg::HoldW-1:0]);

    always_comb begin
        n_hold      = w_hold_upd;
        n_force_off = 1'b0;
        if (w_hold_upd > HoldLimit && i_in.is_pressed) begin
            n_hold      = '0;
            n_force_off = 1'b1;
        end
    end

    // Advance lock state on each accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry  <= 1'b0;
            r_wtimer <= '0;
            r_count  <= '0;
            r_pos    <= '0;
            r_hold   <= '0;
        end else if (w_accept) begin
            r_entry  <= n_entry;
            r_wtimer <= n_wtimer;
            r_count  <= n_count;
            r_pos    <= n_pos;
            r_hold   <= n_hold;
        end
    end

    // Result register valid: fill on accept, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_power_on  <= n_power_on;
            r_force_off <= n_force_off;
            r_blink     <= n_blink;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.power_on      = r_power_on;
    assign o_out.force_off     = r_force_off;
    assign o_out.blink_blue    = r_blink;
    assign o_out.entering_code = r_entry;

    // Entry always runs at a real digit position
    a_entry_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_entry |-> r_pos != '0)
        else $error("entry active at position zero");

    // A blink keeps entry going and never comes with power on
    a_blink_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.blink_blue) |-> (o_out.entering_code && !o_out.power_on))
        else $error("blink without ongoing entry");

    // Power on always ends entry
    a_power_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.power_on) |-> !o_out.entering_code)
        else $error("power on while still entering");

    // Every accepted tick shows up as a result next cycle
    a_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_out.valid)
        else $error("accepted tick produced no result");

endmodule

FILE: hdl/bpcl_cfg_regs.sv
// Configuration register file of the button press code lock.
// Converts the window length to milliseconds on write; uses bpcl_pkg.
`timescale 1ns / 1ps

module bpcl_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [bpcl_pkg::CfgIdxW-1:0]  i_cfg_idx,
    input  logic [bpcl_pkg::CfgDataW-1:0] i_cfg_data,
    output bpcl_pkg::t_cfg                o_cfg
);

    bpcl_pkg::t_cfg             r_cfg;
    logic [bpcl_pkg::LimitW-1:0] w_limit;

    // Seconds to milliseconds, taken once per write
    assign w_limit = bpcl_pkg::LimitW'(i_cfg_data)
                   * bpcl_pkg::LimitW'(bpcl_pkg::MS_PER_SECOND);

    // Store a written register; indexes beyond the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.window_limit <= bpcl_pkg::LimitW'(2 * bpcl_pkg::MS_PER_SECOND);
            r_cfg.digit_one    <= 4'd1;
            r_cfg.digit_two    <= 4'd1;
            r_cfg.digit_three  <= 4'd1;
            r_cfg.code_length  <= 2'd0;
            r_cfg.lock_enable  <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bpcl_pkg::CFG_WINDOW_SECONDS: r_cfg.window_limit <= w_limit;
                bpcl_pkg::CFG_DIGIT_ONE:      r_cfg.digit_one    <= i_cfg_data[3:0];
                bpcl_pkg::CFG_DIGIT_TWO:      r_cfg.digit_two    <= i_cfg_data[3:0];
                bpcl_pkg::CFG_DIGIT_THREE:    r_cfg.digit_three  <= i_cfg_data[3:0];
                bpcl_pkg::CFG_CODE_LENGTH:    r_cfg.code_length  <= i_cfg_data[1:0];
                bpcl_pkg::CFG_LOCK_ENABLE:    r_cfg.lock_enable  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule
